[design/buffer_pool_page_replacement_macros.svh]
// ----------------------------------------------------------------------------
// Buffer pool assertion macros
// Concurrent assertion wrappers shared by the buffer pool RTL; they compile to
// nothing when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH
`define BUFFER_POOL_PAGE_REPLACEMENT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define BPR_ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define BPR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BPR_ASSERT_RST(label, clk, rst_n, prop, msg)
`define BPR_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[design/bpr_pkg.sv]
// ----------------------------------------------------------------------------
// Buffer pool package
// Types, codes and helpers shared by the buffer pool frame table modules.
// ----------------------------------------------------------------------------
package bpr_pkg;

  localparam int unsigned FRAME_W = 3;

  typedef enum logic [2:0] {
    K_PIN   = 3'd0,
    K_UNPIN = 3'd1,
    K_DIRTY = 3'd2,
    K_FORCE = 3'd3,
    K_FLUSH = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_HIT            = 3'd0,
    ST_LOADED_FREE    = 3'd1,
    ST_LOADED_EVICTED = 3'd2,
    ST_DONE           = 3'd3,
    ST_NOT_FOUND      = 3'd4,
    ST_ALL_PINNED     = 3'd5,
    ST_UNDERFLOW      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    IO_NONE  = 2'd0,
    IO_READ  = 2'd1,
    IO_WRITE = 2'd2
  } io_e;

  typedef enum logic [1:0] {
    STRAT_FIFO  = 2'd0,
    STRAT_LRU   = 2'd1,
    STRAT_CLOCK = 2'd2,
    STRAT_LFU   = 2'd3
  } strat_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_HIT,
    S_VICTIM,
    S_EVICT,
    S_LOAD,
    S_FLUSH,
    S_FLUSH_END,
    S_REPLY
  } state_e;

  // Per-frame bookkeeping, everything but the page number.
  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [7:0]  pin;
    logic [31:0] stamp;
    logic        refb;
    logic [15:0] use_cnt;
  } entry_t;

  // Verdict of the compare unit on the frame under the scan pointer.
  typedef struct packed {
    logic matched;
    logic free;
    logic unpinned;
    logic better;
  } eval_t;

  function automatic logic [31:0] sat32(input logic [31:0] v);
    sat32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

[design/bpr_eval.sv]
// ----------------------------------------------------------------------------
// Buffer pool frame compare unit
// Judges one frame per cycle: page match, free, unpinned, and whether it beats
// the best victim found so far under LRU or LFU.
// ----------------------------------------------------------------------------
module bpr_eval import bpr_pkg::*; #(
  parameter int unsigned PAGE_BITS = 20
) (
  input  entry_t               ent_i,
  input  logic [PAGE_BITS-1:0] ent_page_i,
  input  logic [PAGE_BITS-1:0] req_page_i,
  input  logic                 have_best_i,
  input  logic [31:0]          best_stamp_i,
  input  logic [15:0]          best_use_i,
  input  strat_e               strategy_i,
  output eval_t                eval_o
);

  always_comb begin
    eval_o.matched  = ent_i.valid && (ent_page_i == req_page_i);
    eval_o.free     = !ent_i.valid;
    eval_o.unpinned = (ent_i.pin == 8'd0);
    case (strategy_i)
      STRAT_LRU: eval_o.better = !have_best_i || (ent_i.stamp < best_stamp_i);
      STRAT_LFU: eval_o.better = !have_best_i || (ent_i.use_cnt < best_use_i);
      default:   eval_o.better = !have_best_i;
    endcase
  end

endmodule

[design/buffer_pool_page_replacement.sv]
// ----------------------------------------------------------------------------
// Buffer pool page replacement
// Page-frame table of a buffer pool with FIFO, LRU, CLOCK and LFU eviction.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. The block then walks
// the frame table one frame per cycle through a single compare unit: a lookup
// scans the frames, a pin miss on a full pool adds a victim scan (CLOCK may go
// round the table more than once) plus an evict step for the write-back and a
// load step for the read, and flush all visits every frame. Every result is
// shown for exactly one cycle on valid_o and must be taken then; the receiver
// cannot stall. A request ends with a result that has last_o set; a dirty
// eviction gives a write-back transaction followed by the read transaction on
// consecutive cycles. The strategy register may be written only while busy is
// low.
`include "buffer_pool_page_replacement_macros.svh"

module buffer_pool_page_replacement import bpr_pkg::*; #(
  parameter int unsigned FRAMES    = 8,
  parameter int unsigned PAGE_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           kind_i,
  input  logic [PAGE_BITS-1:0] page_number_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_strategy_i,
  output logic                 valid_o,
  output logic [2:0]           status_o,
  output logic [2:0]           frame_o,
  output logic [1:0]           io_kind_o,
  output logic [PAGE_BITS-1:0] io_page_o,
  output logic [31:0]          read_total_o,
  output logic [31:0]          write_total_o,
  output logic                 last_o
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(2 * FRAMES + 2);
  localparam logic [IW-1:0] LAST_IDX = IW'(FRAMES - 1);

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
    wrap_inc = (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  // Frame table. Page numbers have no reset; an empty frame's page is never used.
  entry_t               ent_q [FRAMES];
  logic [PAGE_BITS-1:0] frame_page_q [FRAMES];

  // Global counters and policy pointers.
  logic [31:0]   acc_q, acc_d, rd_q, rd_d, wr_q, wr_d;
  logic [IW-1:0] hand_q, hand_d, lfu_q, lfu_d, fifo_q, fifo_d;
  strat_e        strat_q;

  // Sequencer registers.
  state_e               state_q, state_d;
  logic [2:0]           kind_q, kind_d;
  logic [PAGE_BITS-1:0] pg_q, pg_d;
  logic [IW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 ff_q, ff_d;
  logic [IW-1:0]        free_idx_q, free_idx_d;
  logic                 vf_q, vf_d;
  logic [IW-1:0]        vic_q, vic_d;
  logic [31:0]          best_stamp_q, best_stamp_d;
  logic [15:0]          best_use_q, best_use_d;
  status_e              lst_q, lst_d, reply_q, reply_d;
  logic                 pend_q, pend_d;
  logic [IW-1:0]        pend_idx_q, pend_idx_d;
  logic [PAGE_BITS-1:0] pend_page_q, pend_page_d;
  logic [31:0]          pend_wt_q, pend_wt_d;

  // Result registers.
  logic                 res_valid_q;
  status_e              res_status_q;
  logic [IW-1:0]        res_frame_q;
  io_e                  res_io_q;
  logic [PAGE_BITS-1:0] res_page_q;
  logic [31:0]          res_rt_q, res_wt_q;
  logic                 res_last_q;

  // Result being produced this cycle.
  logic                 em;
  status_e              em_status;
  logic [IW-1:0]        em_frame;
  io_e                  em_io;
  logic [PAGE_BITS-1:0] em_page;
  logic [31:0]          em_rt, em_wt;
  logic                 em_last;

  // Table write port, always at the scan pointer.
  logic   ent_we, page_we;
  entry_t ent_d;

  entry_t               cur;
  logic [PAGE_BITS-1:0] cur_page;
  eval_t                ev;
  logic                 accept, last_idx;

  // Victim scan decisions.
  logic          v_take, v_none, v_upd, v_clr;
  logic [IW-1:0] v_pick;

  assign cur      = ent_q[idx_q];
  assign cur_page = frame_page_q[idx_q];
  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign last_idx = (idx_q == LAST_IDX);
  assign cfg_ready_o = (state_q == S_IDLE);

  bpr_eval #(
    .PAGE_BITS(PAGE_BITS)
  ) u_eval (
    .ent_i       (cur),
    .ent_page_i  (cur_page),
    .req_page_i  (pg_q),
    .have_best_i (vf_q),
    .best_stamp_i(best_stamp_q),
    .best_use_i  (best_use_q),
    .strategy_i  (strat_q),
    .eval_o      (ev)
  );

  // Per-policy victim selection for the frame under the pointer.
  always_comb begin
    v_take = 1'b0;
    v_none = 1'b0;
    v_upd  = 1'b0;
    v_clr  = 1'b0;
    v_pick = idx_q;
    case (strat_q)
      STRAT_FIFO: begin
        v_take = ev.unpinned;
        v_none = !ev.unpinned && (cnt_q == CW'(FRAMES - 1));
      end
      STRAT_CLOCK: begin
        // Pinned frames keep their reference bit; set bits get a second chance.
        v_take = ev.unpinned && !cur.refb;
        v_clr  = ev.unpinned && cur.refb;
        v_none = !v_take && (cnt_q == CW'(2 * FRAMES));
      end
      default: begin
        v_upd  = ev.unpinned && ev.better;
        v_pick = v_upd ? idx_q : vic_q;
        v_take = (cnt_q == CW'(FRAMES - 1)) && (vf_q || v_upd);
        v_none = (cnt_q == CW'(FRAMES - 1)) && !(vf_q || v_upd);
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (kind_i > K_FLUSH) begin
            state_d = S_REPLY;
          end else if (kind_i == K_FLUSH) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_FIND;
          end
        end
      end
      S_FIND: begin
        if (ev.matched) begin
          state_d = S_HIT;
        end else if (last_idx) begin
          if (kind_q != K_PIN) begin
            state_d = S_REPLY;
          end else if (ff_q || ev.free) begin
            state_d = S_LOAD;
          end else begin
            state_d = S_VICTIM;
          end
        end
      end
      S_VICTIM: begin
        if (v_take) begin
          state_d = S_EVICT;
        end else if (v_none) begin
          state_d = S_REPLY;
        end
      end
      S_EVICT:     state_d = S_LOAD;
      S_FLUSH:     state_d = last_idx ? S_FLUSH_END : S_FLUSH;
      S_HIT,
      S_LOAD,
      S_FLUSH_END,
      S_REPLY:     state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  // Datapath actions and results.
  always_comb begin
    kind_d       = kind_q;
    pg_d         = pg_q;
    idx_d        = idx_q;
    cnt_d        = cnt_q;
    ff_d         = ff_q;
    free_idx_d   = free_idx_q;
    vf_d         = vf_q;
    vic_d        = vic_q;
    best_stamp_d = best_stamp_q;
    best_use_d   = best_use_q;
    lst_d        = lst_q;
    reply_d      = reply_q;
    pend_d       = pend_q;
    pend_idx_d   = pend_idx_q;
    pend_page_d  = pend_page_q;
    pend_wt_d    = pend_wt_q;
    acc_d        = acc_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    hand_d       = hand_q;
    lfu_d        = lfu_q;
    fifo_d       = fifo_q;
    ent_we       = 1'b0;
    page_we      = 1'b0;
    ent_d        = cur;
    em           = 1'b0;
    em_status    = ST_DONE;
    em_frame     = '0;
    em_io        = IO_NONE;
    em_page      = '0;
    em_rt        = rd_q;
    em_wt        = wr_q;
    em_last      = 1'b1;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d  = kind_i;
          pg_d    = page_number_i;
          idx_d   = '0;
          cnt_d   = '0;
          ff_d    = 1'b0;
          pend_d  = 1'b0;
          reply_d = ST_NOT_FOUND;
        end
      end
      S_REPLY: begin
        em        = 1'b1;
        em_status = reply_q;
      end
      S_FIND: begin
        if (!ev.matched) begin
          if (ev.free && !ff_q) begin
            ff_d       = 1'b1;
            free_idx_d = idx_q;
          end
          if (last_idx) begin
            if (kind_q != K_PIN) begin
              reply_d = ST_NOT_FOUND;
            end else if (ff_q) begin
              idx_d = free_idx_q;
              lst_d = ST_LOADED_FREE;
            end else if (ev.free) begin
              lst_d = ST_LOADED_FREE;
            end else begin
              // Pool full: set up the victim scan at the policy's start point.
              lst_d = ST_LOADED_EVICTED;
              cnt_d = '0;
              vf_d  = 1'b0;
              case (strat_q)
                STRAT_FIFO:  idx_d = fifo_q;
                STRAT_CLOCK: idx_d = hand_q;
                STRAT_LFU:   idx_d = lfu_q;
                default:     idx_d = '0;
              endcase
            end
          end else begin
            idx_d = wrap_inc(idx_q);
          end
        end
      end
      S_HIT: begin
        em       = 1'b1;
        em_frame = idx_q;
        case (kind_q)
          K_PIN: begin
            acc_d         = sat32(acc_q);
            ent_we        = 1'b1;
            ent_d.pin     = (cur.pin == 8'hFF) ? cur.pin : cur.pin + 8'd1;
            ent_d.stamp   = acc_d;
            ent_d.refb    = 1'b1;
            ent_d.use_cnt = (cur.use_cnt == 16'hFFFF) ? cur.use_cnt : cur.use_cnt + 16'd1;
            em_status     = ST_HIT;
          end
          K_UNPIN: begin
            if (cur.pin == 8'd0) begin
              em_status = ST_UNDERFLOW;
            end else begin
              ent_we    = 1'b1;
              ent_d.pin = cur.pin - 8'd1;
            end
          end
          K_DIRTY: begin
            ent_we      = 1'b1;
            ent_d.dirty = 1'b1;
          end
          K_FORCE: begin
            // Written back even when clean or pinned.
            ent_we      = 1'b1;
            ent_d.dirty = 1'b0;
            wr_d        = sat32(wr_q);
            em_io       = IO_WRITE;
            em_page     = pg_q;
            em_wt       = wr_d;
          end
          default: begin
            em_status = ST_NOT_FOUND;
            em_frame  = '0;
          end
        endcase
      end
      S_VICTIM: begin
        if (v_clr) begin
          ent_we     = 1'b1;
          ent_d.refb = 1'b0;
        end
        if (v_upd) begin
          vf_d         = 1'b1;
          vic_d        = idx_q;
          best_stamp_d = cur.stamp;
          best_use_d   = cur.use_cnt;
        end
        if (v_take) begin
          idx_d = v_pick;
          if (strat_q == STRAT_CLOCK) begin
            hand_d = wrap_inc(idx_q);
          end
          if (strat_q == STRAT_LFU) begin
            lfu_d = wrap_inc(v_pick);
          end
        end else if (v_none) begin
          reply_d = ST_ALL_PINNED;
        end else begin
          idx_d = wrap_inc(idx_q);
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_EVICT: begin
        if (cur.dirty) begin
          wr_d      = sat32(wr_q);
          em        = 1'b1;
          em_status = ST_LOADED_EVICTED;
          em_frame  = idx_q;
          em_io     = IO_WRITE;
          em_page   = cur_page;
          em_wt     = wr_d;
          em_last   = 1'b0;
        end
      end
      S_LOAD: begin
        rd_d = sat32(rd_q);
        if (rd_q != 32'hFFFF_FFFF) begin
          fifo_d = wrap_inc(fifo_q);
        end
        acc_d   = sat32(acc_q);
        page_we = 1'b1;
        ent_we  = 1'b1;
        ent_d.valid   = 1'b1;
        ent_d.dirty   = 1'b0;
        ent_d.pin     = 8'd1;
        ent_d.stamp   = acc_d;
        ent_d.refb    = 1'b1;
        ent_d.use_cnt = 16'd0;
        em        = 1'b1;
        em_status = lst_q;
        em_frame  = idx_q;
        em_io     = IO_READ;
        em_page   = pg_q;
        em_rt     = rd_d;
      end
      S_FLUSH: begin
        // Each write is held in the pending registers so the final one can carry last.
        if (cur.valid && cur.dirty && ev.unpinned) begin
          ent_we      = 1'b1;
          ent_d.dirty = 1'b0;
          wr_d        = sat32(wr_q);
          if (pend_q) begin
            em        = 1'b1;
            em_frame  = pend_idx_q;
            em_io     = IO_WRITE;
            em_page   = pend_page_q;
            em_wt     = pend_wt_q;
            em_last   = 1'b0;
          end
          pend_d      = 1'b1;
          pend_idx_d  = idx_q;
          pend_page_d = cur_page;
          pend_wt_d   = wr_d;
        end
        if (!last_idx) begin
          idx_d = wrap_inc(idx_q);
        end
      end
      S_FLUSH_END: begin
        em = 1'b1;
        if (pend_q) begin
          em_frame = pend_idx_q;
          em_io    = IO_WRITE;
          em_page  = pend_page_q;
          em_wt    = pend_wt_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Frame table storage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        ent_q[i] <= '0;
      end
    end else if (ent_we) begin
      ent_q[idx_q] <= ent_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (page_we) begin
      frame_page_q[idx_q] <= pg_q;
    end
  end

  // Control, counters and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      strat_q <= STRAT_FIFO;
      acc_q   <= '0;
      rd_q    <= '0;
      wr_q    <= '0;
      hand_q  <= '0;
      lfu_q   <= '0;
      fifo_q  <= '0;
      ff_q    <= 1'b0;
      vf_q    <= 1'b0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        strat_q <= strat_e'(cfg_strategy_i);
      end
      acc_q  <= acc_d;
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      hand_q <= hand_d;
      lfu_q  <= lfu_d;
      fifo_q <= fifo_d;
      ff_q   <= ff_d;
      vf_q   <= vf_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      res_valid_q <= em;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    pg_q         <= pg_d;
    free_idx_q   <= free_idx_d;
    vic_q        <= vic_d;
    best_stamp_q <= best_stamp_d;
    best_use_q   <= best_use_d;
    lst_q        <= lst_d;
    reply_q      <= reply_d;
    pend_idx_q   <= pend_idx_d;
    pend_page_q  <= pend_page_d;
    pend_wt_q    <= pend_wt_d;
    if (em) begin
      res_status_q <= em_status;
      res_frame_q  <= em_frame;
      res_io_q     <= em_io;
      res_page_q   <= em_page;
      res_rt_q     <= em_rt;
      res_wt_q     <= em_wt;
      res_last_q   <= em_last;
    end
  end

  assign valid_o       = res_valid_q;
  assign status_o      = res_status_q;
  assign frame_o       = FRAME_W'(res_frame_q);
  assign io_kind_o     = res_io_q;
  assign io_page_o     = res_page_q;
  assign read_total_o  = res_rt_q;
  assign write_total_o = res_wt_q;
  assign last_o        = res_last_q;

  // A result only ever follows a cycle of work on a request.
  `BPR_ASSERT_RST(a_result_from_work, clk_i, rst_ni, res_valid_q |-> $past(state_q != S_IDLE), "result without a request in progress")
  // The final result of a request leaves the sequencer idle.
  `BPR_ASSERT_RST(a_last_idle, clk_i, rst_ni, (res_valid_q && res_last_q) |-> (state_q == S_IDLE), "sequencer still busy after final result")
  // A write-back of an evicted page is followed at once by the page read.
  `BPR_ASSERT_RST(a_evict_then_read, clk_i, rst_ni, (res_valid_q && res_io_q == IO_WRITE && res_status_q == ST_LOADED_EVICTED) |=> (res_valid_q && res_io_q == IO_READ && res_last_q), "eviction write-back not followed by read")
  // A non-final result is always a page write-back.
  `BPR_ASSERT_ALWAYS(a_partial_is_write, clk_i, !(res_valid_q && !res_last_q && res_io_q != IO_WRITE), "non-final result without write-back")
  // The disk totals never move backward.
  `BPR_ASSERT_RST(a_totals_monotonic, clk_i, rst_ni, (rd_q >= $past(rd_q)) && (wr_q >= $past(wr_q)), "disk total decreased")

endmodule
